[rtl/gdfw_pkg.sv]
// Shared types and constants of the grid depth-first walk block.
package gdfw_pkg;

	// Field widths of the item, result and config channels.
	localparam int ROW_FW     = 6;
	localparam int COL_FW     = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;

	// Item kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	// Next-direction codes of a stack entry, in trial order.
	localparam int DIR_W = 3;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

	// Width of the visited-map epoch mark.
	localparam int EPOCH_W = 8;

	// Datapath operations issued by the control word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_EPOCH_ZERO,
		OP_TAKE,
		OP_START,
		OP_TRY,
		OP_VISIT,
		OP_POP,
		OP_LOAD,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic take;
		logic xfer;
	} ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic pend;
		logic kind_next;
		logic epoch_max;
		logic empty;
		logic top_end;
		logic off_grid;
		logic seen;
	} flags_t;

	typedef struct packed {
		logic [ROW_FW-1:0] cell_row;
		logic [COL_FW-1:0] cell_col;
		logic              emitted;
		logic              done_res;
	} res_t;

endpackage

[rtl/gdfw_in_if.sv]
// Item channel: walk commands into the block.
interface gdfw_in_if;
	import gdfw_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [ROW_FW-1:0] start_row;
	logic [COL_FW-1:0] start_col;

	modport source (output valid, kind, start_row, start_col, input ready);
	modport sink   (input valid, kind, start_row, start_col, output ready);
endinterface

[rtl/gdfw_out_if.sv]
// Result channel: visited cells and done reports out of the block.
interface gdfw_out_if;
	import gdfw_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROW_FW-1:0] cell_row;
	logic [COL_FW-1:0] cell_col;
	logic              emitted;
	logic              done_res;

	modport source (output valid, cell_row, cell_col, emitted, done_res, input ready);
	modport sink   (input valid, cell_row, cell_col, emitted, done_res, output ready);
endinterface

[rtl/gdfw_cfg_if.sv]
// Configuration write channel.
interface gdfw_cfg_if;
	import gdfw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/gdfw_useq.sv]
// Microcode sequencer: step counter, control-word ROM and branch logic.
module gdfw_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	input  gdfw_pkg::flags_t flags,
	output gdfw_pkg::ctrl_t  ctrl
);
	import gdfw_pkg::*;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		BR_ALWAYS,
		BR_CLR_MORE,
		BR_PEND,
		BR_NO_XFER,
		BR_KIND_NEXT,
		BR_EPOCH_MAX,
		BR_EMPTY,
		BR_TOP_END,
		BR_OFF_GRID,
		BR_SEEN
	} br_t;

	typedef struct packed {
		op_t   op;
		br_t   br;
		step_t tgt;
	} uword_t;

	localparam step_t S_CLR     = 4'd0;
	localparam step_t S_CLR_END = 4'd1;
	localparam step_t S_IDLE    = 4'd2;
	localparam step_t S_KIND    = 4'd3;
	localparam step_t S_EPCHK   = 4'd4;
	localparam step_t S_START   = 4'd5;
	localparam step_t S_NEXT    = 4'd6;
	localparam step_t S_DIR     = 4'd7;
	localparam step_t S_TRY     = 4'd8;
	localparam step_t S_CHECK   = 4'd9;
	localparam step_t S_VISIT   = 4'd10;
	localparam step_t S_POP     = 4'd11;
	localparam step_t S_LOAD    = 4'd12;
	localparam step_t S_DONE    = 4'd13;

	// Program: jump to tgt when the branch condition holds, else fall through.
	function automatic uword_t rom(input step_t s);
		uword_t w;
		case (s)
			S_CLR:     w = '{OP_CLR,        BR_CLR_MORE,  S_CLR};
			S_CLR_END: w = '{OP_EPOCH_ZERO, BR_PEND,      S_START};
			S_IDLE:    w = '{OP_TAKE,       BR_NO_XFER,   S_IDLE};
			S_KIND:    w = '{OP_NONE,       BR_KIND_NEXT, S_NEXT};
			S_EPCHK:   w = '{OP_NONE,       BR_EPOCH_MAX, S_CLR};
			S_START:   w = '{OP_START,      BR_ALWAYS,    S_IDLE};
			S_NEXT:    w = '{OP_NONE,       BR_EMPTY,     S_DONE};
			S_DIR:     w = '{OP_NONE,       BR_TOP_END,   S_POP};
			S_TRY:     w = '{OP_TRY,        BR_OFF_GRID,  S_DIR};
			S_CHECK:   w = '{OP_NONE,       BR_SEEN,      S_DIR};
			S_VISIT:   w = '{OP_VISIT,      BR_ALWAYS,    S_IDLE};
			S_POP:     w = '{OP_POP,        BR_ALWAYS,    S_LOAD};
			S_LOAD:    w = '{OP_LOAD,       BR_ALWAYS,    S_NEXT};
			S_DONE:    w = '{OP_DONE,       BR_ALWAYS,    S_IDLE};
			default:   w = '{OP_NONE,       BR_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

	step_t  step_q;
	uword_t uw;
	logic   emit;
	logic   stall;
	logic   xfer;
	logic   jump;

	always_comb begin
		uw    = rom(step_q);
		emit  = uw.op inside {OP_START, OP_VISIT, OP_DONE};
		stall = emit && !out_free;
		xfer  = (uw.op == OP_TAKE) && in_valid;
		case (uw.br)
			BR_ALWAYS:    jump = 1'b1;
			BR_CLR_MORE:  jump = !flags.clr_last;
			BR_PEND:      jump = flags.pend;
			BR_NO_XFER:   jump = !xfer;
			BR_KIND_NEXT: jump = flags.kind_next;
			BR_EPOCH_MAX: jump = flags.epoch_max;
			BR_EMPTY:     jump = flags.empty;
			BR_TOP_END:   jump = flags.top_end;
			BR_OFF_GRID:  jump = flags.off_grid;
			BR_SEEN:      jump = flags.seen;
			default:      jump = 1'b0;
		endcase
		ctrl.op   = stall ? OP_NONE : uw.op;
		ctrl.take = (uw.op == OP_TAKE);
		ctrl.xfer = xfer;
	end

	// Hold the step while a result waits for room in the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_CLR;
		end else if (!stall) begin
			step_q <= jump ? uw.tgt : step_q + step_t'(1);
		end
	end

	a_try_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_TRY |=> step_q == S_DIR || step_q == S_CHECK)
		else $error("try step did not advance to a check");

	a_xfer_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.xfer |=> step_q == S_KIND)
		else $error("accepted item not dispatched");

endmodule

[rtl/gdfw_dpath.sv]
// Walk datapath: visited map, walk stack, top-of-stack and candidate registers.
module gdfw_dpath #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gdfw_pkg::ctrl_t             ctrl,
	input  logic                        wipe,
	input  logic                        kind,
	input  logic [gdfw_pkg::ROW_FW-1:0] start_row,
	input  logic [gdfw_pkg::COL_FW-1:0] start_col,
	input  logic [RW-1:0]               lim_r,
	input  logic [CW-1:0]               lim_c,
	output gdfw_pkg::flags_t            flags,
	output logic                        res_valid,
	output gdfw_pkg::res_t              res
);
	import gdfw_pkg::*;

	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = AW + 1;
	localparam int EW    = RW + CW + DIR_W;

	// Visited map holds an epoch mark per cell; a cell is visited when its
	// mark equals the current epoch.
	logic [EPOCH_W-1:0] vis_mem [DEPTH];
	logic [EW-1:0]      stk_mem [DEPTH];

	logic               pend_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      clr_q;
	logic [SW-1:0]      sp_q;

	logic               kind_q;
	logic [ROW_FW-1:0]  srow_q;
	logic [COL_FW-1:0]  scol_q;
	logic [RW-1:0]      top_r_q;
	logic [CW-1:0]      top_c_q;
	logic [DIR_W-1:0]   top_dir_q;
	logic [RW-1:0]      cand_r_q;
	logic [CW-1:0]      cand_c_q;
	logic [EPOCH_W-1:0] vis_rd_q;
	logic [EW-1:0]      stk_rd_q;

	logic [RW-1:0]      sat_r;
	logic [CW-1:0]      sat_c;
	logic [RW-1:0]      nb_r;
	logic [CW-1:0]      nb_c;
	logic               off;
	logic               vis_we;
	logic [AW-1:0]      vis_wa;
	logic [EPOCH_W-1:0] vis_wd;
	logic [AW-1:0]      stk_wa;
	logic [AW-1:0]      stk_ra;

	// Clamp the start cell into the grid.
	always_comb begin
		sat_r = (int'(srow_q) > int'(lim_r)) ? lim_r : RW'(srow_q);
		sat_c = (int'(scol_q) > int'(lim_c)) ? lim_c : CW'(scol_q);
	end

	// Neighbour of the top entry in its next direction.
	always_comb begin
		nb_r = top_r_q;
		nb_c = top_c_q;
		off  = 1'b1;
		case (top_dir_q)
			DIR_UP: begin
				nb_r = top_r_q - RW'(1);
				off  = (top_r_q == '0);
			end
			DIR_RIGHT: begin
				nb_c = top_c_q + CW'(1);
				off  = (top_c_q == lim_c);
			end
			DIR_DOWN: begin
				nb_r = top_r_q + RW'(1);
				off  = (top_r_q == lim_r);
			end
			DIR_LEFT: begin
				nb_c = top_c_q - CW'(1);
				off  = (top_c_q == '0);
			end
			default: ;
		endcase
	end

	always_comb begin
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = '0;
		case (ctrl.op)
			OP_CLR: vis_we = 1'b1;
			OP_START: begin
				vis_we = 1'b1;
				vis_wa = {sat_r, sat_c};
				vis_wd = epoch_q + EPOCH_W'(1);
			end
			OP_VISIT: begin
				vis_we = 1'b1;
				vis_wa = {cand_r_q, cand_c_q};
				vis_wd = epoch_q;
			end
			default: ;
		endcase
		stk_wa = AW'(sp_q - SW'(1));
		stk_ra = AW'(sp_q - SW'(2));
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (ctrl.op == OP_TRY) begin
			vis_rd_q <= vis_mem[{nb_r, nb_c}];
		end
	end

	// The top entry lives in registers; the memory holds the frames below it.
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_VISIT) begin
			stk_mem[stk_wa] <= {top_r_q, top_c_q, top_dir_q};
		end
		if (ctrl.op == OP_POP) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			epoch_q <= '0;
			clr_q   <= '0;
			sp_q    <= '0;
		end else begin
			case (ctrl.op)
				OP_TAKE:       if (ctrl.xfer) pend_q <= (kind == KIND_START);
				OP_CLR:        clr_q <= clr_q + AW'(1);
				OP_EPOCH_ZERO: epoch_q <= '0;
				OP_START: begin
					pend_q  <= 1'b0;
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
				default: ;
			endcase
			if (wipe) begin
				sp_q <= '0;
			end else begin
				case (ctrl.op)
					OP_START: sp_q <= SW'(1);
					OP_VISIT: sp_q <= sp_q + SW'(1);
					OP_POP:   sp_q <= sp_q - SW'(1);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_TAKE: begin
				if (ctrl.xfer) begin
					kind_q <= kind;
					srow_q <= start_row;
					scol_q <= start_col;
				end
			end
			OP_START: begin
				top_r_q   <= sat_r;
				top_c_q   <= sat_c;
				top_dir_q <= DIR_UP;
			end
			OP_TRY: begin
				top_dir_q <= top_dir_q + DIR_W'(1);
				cand_r_q  <= nb_r;
				cand_c_q  <= nb_c;
			end
			OP_VISIT: begin
				top_r_q   <= cand_r_q;
				top_c_q   <= cand_c_q;
				top_dir_q <= DIR_UP;
			end
			OP_LOAD: begin
				top_r_q   <= stk_rd_q[EW-1 -: RW];
				top_c_q   <= stk_rd_q[DIR_W +: CW];
				top_dir_q <= stk_rd_q[DIR_W-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		flags.clr_last  = &clr_q;
		flags.pend      = pend_q;
		flags.kind_next = (kind_q == KIND_NEXT);
		flags.epoch_max = &epoch_q;
		flags.empty     = (sp_q == '0);
		flags.top_end   = (top_dir_q == DIR_END);
		flags.off_grid  = off;
		flags.seen      = (vis_rd_q == epoch_q);

		res_valid = 1'b0;
		res       = '0;
		case (ctrl.op)
			OP_START: begin
				res_valid    = 1'b1;
				res.cell_row = ROW_FW'(sat_r);
				res.cell_col = COL_FW'(sat_c);
				res.emitted  = 1'b1;
			end
			OP_VISIT: begin
				res_valid    = 1'b1;
				res.cell_row = ROW_FW'(cand_r_q);
				res.cell_col = COL_FW'(cand_c_q);
				res.emitted  = 1'b1;
			end
			OP_DONE: begin
				res_valid    = 1'b1;
				res.done_res = 1'b1;
			end
			default: ;
		endcase
	end

	a_try_live_dir: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_TRY |-> top_dir_q != DIR_END)
		else $error("neighbour tried on an exhausted entry");

	a_start_top: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_START |=> top_dir_q == DIR_UP)
		else $error("start did not seed the top entry");

	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.emitted ^ res.done_res))
		else $error("result neither a cell nor done");

endmodule

[rtl/grid_depth_first_walk_top.sv]
// Top level of the grid depth-first walk: config registers, output register, core.
//
//   channel  dir   handshake     payload
//   item     in    valid/ready   kind, start_row, start_col
//   result   out   valid/ready   cell_row, cell_col, emitted, done_res
//   cfg      in    valid/ready   index, data (rows = 0, cols = 1)
//
// A start seeds the walk at its clamped start cell; a next tries neighbors of the
// top entry, skipping those off the grid or already visited and popping
// exhausted stack frames, until it takes one; on an empty stack it reports done.
// Each item runs alone through the microcode sequencer and one datapath.
// Reset: a clearing pass runs over the visited map; the same pass runs
// again inside the start that finds the epoch mark at its maximum (the
// 256th start after reset, then every 255th). No item is taken meanwhile.
// Stalls: a result waits in the output register; the sequencer holds only
// when it has a new result and the register is still full.
module grid_depth_first_walk_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	gdfw_in_if.sink    item,
	gdfw_out_if.source result,
	gdfw_cfg_if.sink   cfg
);
	import gdfw_pkg::*;

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int NRW = $clog2(MAX_ROWS + 1);
	localparam int NCW = $clog2(MAX_COLS + 1);

	logic [CFG_DATA_W-1:0] rows_q;
	logic [CFG_DATA_W-1:0] cols_q;
	logic [NRW-1:0]        eff_r;
	logic [NCW-1:0]        eff_c;
	logic [RW-1:0]         lim_r;
	logic [CW-1:0]         lim_c;
	logic                  wipe;

	logic                  out_valid_q;
	res_t                  out_q;
	logic                  out_free;

	ctrl_t                 ctrl;
	flags_t                flags;
	logic                  res_valid;
	res_t                  res_d;

	// Config port never stalls. A write to either register ends the walk.
	assign cfg.ready = 1'b1;
	assign wipe = cfg.valid && (cfg.index == CFG_ROWS || cfg.index == CFG_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_DATA_W'(1);
			cols_q <= CFG_DATA_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ROWS: rows_q <= cfg.data;
				CFG_COLS: cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamp the grid size into 1..MAX; zero acts as one. Keep the last
	// row and column index for the bounds checks.
	always_comb begin
		if (rows_q == '0) begin
			eff_r = NRW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			eff_r = NRW'(MAX_ROWS);
		end else begin
			eff_r = NRW'(rows_q);
		end
		if (cols_q == '0) begin
			eff_c = NCW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			eff_c = NCW'(MAX_COLS);
		end else begin
			eff_c = NCW'(cols_q);
		end
		lim_r = RW'(eff_r - NRW'(1));
		lim_c = CW'(eff_c - NCW'(1));
	end

	// Ready only while the sequencer sits on its take step.
	assign item.ready = ctrl.take;

	// Output register: room when empty or draining in this cycle.
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res_d;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.cell_row = out_q.cell_row;
	assign result.cell_col = out_q.cell_col;
	assign result.emitted  = out_q.emitted;
	assign result.done_res = out_q.done_res;

	gdfw_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.out_free (out_free),
		.flags    (flags),
		.ctrl     (ctrl)
	);

	gdfw_dpath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.wipe      (wipe),
		.kind      (item.kind),
		.start_row (item.start_row),
		.start_col (item.start_col),
		.lim_r     (lim_r),
		.lim_c     (lim_c),
		.flags     (flags),
		.res_valid (res_valid),
		.res       (res_d)
	);

endmodule

[sim/tb_grid_depth_first_walk_top.sv]
// Testbench of the grid depth-first walk: directed and random walks against a walk model.
`timescale 1ns / 100ps

module tb_grid_depth_first_walk_top;
	import gdfw_pkg::*;

	localparam int MAX_ROWS       = 64;
	localparam int MAX_COLS       = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam int DRAIN_TAIL     = 20;

	logic clk = 1'b0;
	logic arst_n;

	gdfw_in_if  item_bus();
	gdfw_out_if cell_bus();
	gdfw_cfg_if cfg_bus();

	grid_depth_first_walk_top #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(cell_bus),
		.cfg(cfg_bus)
	);

	always #10 clk = ~clk;

	// Walk model: register copies, visited map and the explicit DFS stack.
	logic [CFG_DATA_W-1:0] grid_rows = 7'd1;
	logic [CFG_DATA_W-1:0] grid_cols = 7'd1;
	bit                    visited   [MAX_ROWS*MAX_COLS];
	logic [ROW_FW-1:0]     trail_row [MAX_ROWS*MAX_COLS];
	logic [COL_FW-1:0]     trail_col [MAX_ROWS*MAX_COLS];
	logic [DIR_W-1:0]      trail_dir [MAX_ROWS*MAX_COLS];
	int                    trail_len = 0;

	// Predicted results, oldest first.
	res_t expected_visits[$];

	int          mismatches     = 0;
	int unsigned items_sent     = 0;
	int unsigned quiet_cycles   = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	logic        hold_req;
	int          hold_left;

	// Register value as the block uses it: zero acts as one, large values clip.
	function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return int'(v);
	endfunction

	// Mark a cell visited, push it with its first direction, report it.
	function automatic res_t mark_cell(input int r, input int c);
		res_t res;
		visited[r*MAX_COLS + c] = 1'b1;
		trail_row[trail_len] = r[ROW_FW-1:0];
		trail_col[trail_len] = c[COL_FW-1:0];
		trail_dir[trail_len] = DIR_UP;
		trail_len++;
		res.cell_row = r[ROW_FW-1:0];
		res.cell_col = c[COL_FW-1:0];
		res.emitted  = 1'b1;
		res.done_res = 1'b0;
		return res;
	endfunction

	// Advance the walk by one item and return the result it reports.
	function automatic res_t predict_visit(input logic kind, input logic [ROW_FW-1:0] srow,
			input logic [COL_FW-1:0] scol);
		int nr;
		int nc;
		int r;
		int c;
		logic [DIR_W-1:0] d;
		res_t res;
		nr = clamp_dim(grid_rows, MAX_ROWS);
		nc = clamp_dim(grid_cols, MAX_COLS);
		if (kind == KIND_START) begin
			// Clip the start into the grid and begin afresh.
			r = (int'(srow) > nr - 1) ? nr - 1 : int'(srow);
			c = (int'(scol) > nc - 1) ? nc - 1 : int'(scol);
			foreach (visited[i])
				visited[i] = 1'b0;
			trail_len = 0;
			return mark_cell(r, c);
		end
		while (trail_len > 0) begin
			while (trail_dir[trail_len-1] != DIR_END) begin
				d = trail_dir[trail_len-1];
				r = int'(trail_row[trail_len-1]);
				c = int'(trail_col[trail_len-1]);
				case (d)
					DIR_UP:    r = r - 1;
					DIR_RIGHT: c = c + 1;
					DIR_DOWN:  r = r + 1;
					default:   c = c - 1;
				endcase
				trail_dir[trail_len-1] = d + 1'b1;
				if (r >= 0 && c >= 0 && r < nr && c < nc && !visited[r*MAX_COLS + c])
					return mark_cell(r, c);
			end
			// Dead end: drop the frame and backtrack.
			trail_len--;
		end
		res = '0;
		res.done_res = 1'b1;
		return res;
	endfunction

	// Offer one item, honoring the sender idle rate, and predict it on transfer.
	task automatic send_item(input logic kind, input logic [ROW_FW-1:0] srow,
			input logic [COL_FW-1:0] scol);
		while ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid     <= 1'b1;
		item_bus.kind      <= kind;
		item_bus.start_row <= srow;
		item_bus.start_col <= scol;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		expected_visits = {expected_visits, predict_visit(kind, srow, scol)};
		items_sent++;
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic wait_drained();
		item_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_visits.size() != 0);
	endtask

	// Write one register; call only while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		// Either known register ends the walk; other indexes do nothing.
		if (idx == CFG_ROWS) begin
			grid_rows = val;
			trail_len = 0;
		end else if (idx == CFG_COLS) begin
			grid_cols = val;
			trail_len = 0;
		end
		@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_dim();
		case ($urandom_range(15))
			0:       return '0;
			1:       return CFG_DATA_W'(64);
			2:       return CFG_DATA_W'($urandom_range(127, 65));
			3:       return CFG_DATA_W'($urandom_range(16, 9));
			default: return CFG_DATA_W'($urandom_range(8, 1));
		endcase
	endfunction

	task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Hand-picked items: no walk yet, clipping, zero and oversized registers,
	// an ignored index, and a register write that cuts a walk short.
	task automatic test_directed();
		send_item(KIND_NEXT, 6'd0, 6'd0);
		send_item(KIND_START, 6'd63, 6'd63);
		send_item(KIND_NEXT, 6'd63, 6'd63);
		wait_drained();
		write_reg(CFG_ROWS, 7'd3);
		write_reg(CFG_COLS, 7'd2);
		send_item(KIND_START, 6'd0, 6'd0);
		repeat (7)
			send_item(KIND_NEXT, 6'd0, 6'd0);
		wait_drained();
		write_reg(CFG_ROWS, 7'd0);
		write_reg(CFG_COLS, 7'd127);
		send_item(KIND_START, 6'd63, 6'd63);
		send_item(KIND_NEXT, 6'd21, 6'd42);
		wait_drained();
		write_reg(CFG_IDX_W'(9), 7'd5);
		send_item(KIND_NEXT, 6'd0, 6'd0);
		wait_drained();
		write_reg(CFG_ROWS, 7'd64);
		send_item(KIND_NEXT, 6'd0, 6'd0);
		send_item(KIND_START, 6'd63, 6'd0);
		repeat (4)
			send_item(KIND_NEXT, 6'd63, 6'd63);
		wait_drained();
		write_reg(CFG_ROWS, 7'd65);
		write_reg(CFG_COLS, 7'd1);
		send_item(KIND_START, 6'd0, 6'd0);
		repeat (2)
			send_item(KIND_NEXT, 6'd0, 6'd0);
		wait_drained();
	endtask

	// Stall the result side for a long stretch while items keep coming,
	// then pause until everything is back and carry on.
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_reg(CFG_ROWS, 7'd8);
		write_reg(CFG_COLS, 7'd8);
		send_item(KIND_START, 6'd3, 6'd4);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (24)
			send_item(KIND_NEXT, 6'($urandom_range(63)), 6'($urandom_range(63)));
		wait_drained();
		repeat (8)
			send_item(KIND_NEXT, 6'($urandom_range(63)), 6'($urandom_range(63)));
		wait_drained();
	endtask

	// Mostly well-formed walks on mostly small grids, with stray starts mixed in.
	task automatic test_random_walks(input int unsigned quota);
		int unsigned first;
		int unsigned cells;
		int unsigned steps;
		first = items_sent;
		while (items_sent - first < quota) begin
			if ($urandom_range(9) != 0) begin
				wait_drained();
				write_reg(CFG_ROWS, random_dim());
				write_reg(CFG_COLS, random_dim());
				if ($urandom_range(7) == 0)
					write_reg(CFG_IDX_W'($urandom_range(15, 2)),
						CFG_DATA_W'($urandom_range(127)));
				// Next right after a register write finds no walk.
				if ($urandom_range(9) == 0)
					send_item(KIND_NEXT, 6'($urandom_range(63)), 6'($urandom_range(63)));
			end
			repeat ($urandom_range(3, 1)) begin
				send_item(KIND_START, 6'($urandom_range(63)), 6'($urandom_range(63)));
				cells = clamp_dim(grid_rows, MAX_ROWS) * clamp_dim(grid_cols, MAX_COLS);
				// Usually run the walk out and ask past the end.
				if (cells <= 40 && $urandom_range(9) < 7)
					steps = cells + $urandom_range(1);
				else
					steps = $urandom_range(cells < 40 ? cells : 40);
				repeat (steps) begin
					if ($urandom_range(19) == 0)
						send_item(KIND_START, 6'($urandom_range(63)), 6'($urandom_range(63)));
					else
						send_item(KIND_NEXT, 6'($urandom_range(63)), 6'($urandom_range(63)));
				end
			end
		end
	endtask

	// Result side: random stalls, or a long hold counted here on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			cell_bus.ready <= 1'b0;
			hold_left      <= 0;
		end else if (hold_req) begin
			cell_bus.ready <= 1'b0;
			hold_left      <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			cell_bus.ready <= 1'b0;
			hold_left      <= hold_left - 1;
		end else begin
			cell_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin : check_result
		res_t want;
		if (arst_n && cell_bus.valid && cell_bus.ready) begin
			if (expected_visits.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got %0d %0d %0d %0d",
					$time, cell_bus.cell_row, cell_bus.cell_col, cell_bus.emitted,
					cell_bus.done_res);
				mismatches++;
			end else begin
				want = expected_visits.pop_front();
				check_field("cell_row", 7'(want.cell_row), 7'(cell_bus.cell_row));
				check_field("cell_col", 7'(want.cell_col), 7'(cell_bus.cell_col));
				check_field("emitted", 7'(want.emitted), 7'(cell_bus.emitted));
				check_field("done_res", 7'(want.done_res), 7'(cell_bus.done_res));
			end
		end
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((item_bus.valid && item_bus.ready) || (cell_bus.valid && cell_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_grid_depth_first_walk_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n             = 1'b0;
		hold_req           = 1'b0;
		item_bus.valid     = 1'b0;
		item_bus.kind      = KIND_START;
		item_bus.start_row = '0;
		item_bus.start_col = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = CFG_ROWS;
		cfg_bus.data       = '0;
		cell_bus.ready     = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_output_backpressure();

		// Idle phases: none, sender idle, receiver stalling, both.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_walks(460);
		send_idle_pct  = 81;
		recv_stall_pct = 0;
		test_random_walks(460);
		send_idle_pct  = 0;
		recv_stall_pct = 81;
		test_random_walks(460);
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		test_random_walks(460);

		// Let the last results settle, then watch for strays.
		wait_drained();
		repeat (DRAIN_TAIL)
			@(posedge clk);
		if (mismatches == 0)
			$display("tb_grid_depth_first_walk_top OK");
		else
			$display("tb_grid_depth_first_walk_top NOT OK");
		$finish;
	end

endmodule
